@@ rtl/tdsc_pkg.sv @@
// shared types, codes, constants and character classes for the trie spell checker
`default_nettype none
package tdsc_pkg;

   // payload widths
   localparam int unsigned OP_W     = 2;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LINE_W   = 20;
   localparam int unsigned COL_W    = 16;
   localparam int unsigned LEN_W    = 8;
   localparam int unsigned ERR_W    = 16;
   localparam int unsigned ALPHA_W  = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_DICT_BYTE = 2'd0;
   localparam logic [OP_W-1:0] OP_DICT_END  = 2'd1;
   localparam logic [OP_W-1:0] OP_TEXT_BYTE = 2'd2;
   localparam logic [OP_W-1:0] OP_TEXT_END  = 2'd3;

   // saturation limits
   localparam logic [LINE_W-1:0] LINE_MAX = '1;
   localparam logic [COL_W-1:0]  COL_MAX  = '1;
   localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
   localparam logic [ERR_W-1:0]  ERR_MAX  = '1;

   // characters
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_LF     = 8'h0a;
   localparam logic [7:0] CHR_CR     = 8'h0d;
   localparam logic [7:0] CHR_DOT    = 8'h2e;
   localparam logic [7:0] CHR_COMMA  = 8'h2c;
   localparam logic [7:0] CHR_QUEST  = 8'h3f;
   localparam logic [7:0] CHR_APOS   = 8'h27;
   localparam logic [7:0] CHR_LO_A   = 8'h61;
   localparam logic [7:0] CHR_LO_Z   = 8'h7a;
   localparam logic [7:0] CHR_UP_A   = 8'h41;
   localparam logic [7:0] CHR_UP_Z   = 8'h5a;
   localparam logic [7:0] CASE_DIFF  = 8'h20;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_RD,
      ST_INS_USE,
      ST_MARK,
      ST_LK_RD,
      ST_LK_USE,
      ST_FIN_RD,
      ST_FIN_USE
   } state_type;

   function automatic logic is_lower(input logic [7:0] b);
      return (b >= CHR_LO_A) && (b <= CHR_LO_Z);
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return is_lower(b) || ((b >= CHR_UP_A) && (b <= CHR_UP_Z));
   endfunction

   function automatic logic is_white(input logic [7:0] b);
      return (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
   endfunction

   function automatic logic is_sep(input logic [7:0] b);
      return (b == CHR_SPACE) || (b == CHR_DOT) || (b == CHR_COMMA) ||
             (b == CHR_QUEST) || (b == CHR_TAB) || (b == CHR_LF);
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] b);
      return is_lower(b) ? (b - CASE_DIFF) : b;
   endfunction

endpackage
`default_nettype wire

@@ rtl/tdsc_req_if.sv @@
// request channel: operation and character byte
`default_nettype none
interface tdsc_req_if;
   import tdsc_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [BYTE_W-1:0] byte_req;
   modport source(output valid, output op, output byte_req, input ready);
   modport sink(input valid, input op, input byte_req, output ready);
endinterface
`default_nettype wire

@@ rtl/tdsc_rsp_if.sv @@
// response channel: one misspelling report
`default_nettype none
interface tdsc_rsp_if;
   import tdsc_pkg::*;
   logic             valid;
   logic             ready;
   logic [LINE_W-1:0] line;
   logic [COL_W-1:0]  column;
   logic [LEN_W-1:0]  word_length;
   logic [ERR_W-1:0]  error_count;
   logic              dictionary_full;
   modport source(output valid, output line, output column, output word_length,
                  output error_count, output dictionary_full, input ready);
   modport sink(input valid, input line, input column, input word_length,
                input error_count, input dictionary_full, output ready);
endinterface
`default_nettype wire

@@ rtl/trie_dictionary_spell_checker_core.sv @@
// top level: trie dictionary loader and text spell checker
//
//   channel   dir   handshake     payload
//   req_chan  in    valid/ready   op, byte_req
//   rsp_chan  out   valid/ready   line, column, word_length, error_count, dictionary_full
//
// after reset a clearing pass zeroes the child table and end marks, ready low
// dictionary byte: three read/update passes on the child table, one per walker
// separator or dictionary end closing a token: end mark writes for the walkers not lost
// text letter: a child table lookup, skipped once the word has missed
// word end or file end: an end mark read, held while a report is stalled
// a pending report sits in the output register; new items are taken meanwhile until another report is due
`default_nettype none
module trie_dictionary_spell_checker_core #(
   parameter int unsigned NODE_COUNT = 1024
) (
   input  wire logic      clock,
   input  wire logic      reset,
   tdsc_req_if.sink       req_chan,
   tdsc_rsp_if.source     rsp_chan
);
   import tdsc_pkg::*;

   localparam int unsigned NW          = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int unsigned AW          = NW + ALPHA_W;
   localparam int unsigned CHILD_DEPTH = NODE_COUNT * 256;
   localparam logic [AW-1:0]   SWEEP_LAST = AW'(CHILD_DEPTH - 1);
   localparam logic [NW:0]     POOL_SIZE  = (NW+1)'(NODE_COUNT);

   // memories
   logic [NW-1:0] child_mem [CHILD_DEPTH];
   logic          mark_mem  [NODE_COUNT];
   logic [NW-1:0] child_rd_ff;
   logic          mark_rd_ff;
   logic          child_we;
   logic [AW-1:0] child_waddr, child_raddr;
   logic [NW-1:0] child_wdata;
   logic          mark_we, mark_wdata;
   logic [NW-1:0] mark_waddr, mark_raddr;

   // control and state registers
   state_type     state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [1:0]    wsel_ff, wsel_in;
   logic [NW-1:0] walker_ff [3];
   logic [NW-1:0] walker_in [3];
   logic [2:0]    lost_ff, lost_in;
   logic [7:0]    wbyte_ff [3];
   logic [7:0]    wbyte_in [3];
   logic          in_token_ff, in_token_in;
   logic [NW:0]   nodes_used_ff, nodes_used_in;
   logic          pool_full_ff, pool_full_in;
   logic [NW-1:0] lookup_node_ff, lookup_node_in;
   logic          missed_ff, missed_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [COL_W-1:0]  wstart_ff, wstart_in;
   logic [LEN_W-1:0]  wchars_ff, wchars_in;
   logic [ERR_W-1:0]  errs_ff, errs_in;
   logic              out_valid_ff, out_valid_in;
   logic [LINE_W-1:0] out_line_ff, out_line_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic [ERR_W-1:0]  out_errs_ff, out_errs_in;
   logic              out_full_ff, out_full_in;

   logic          report;
   logic [7:0]    up_byte;

   // child table and end marks, registered reads
   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_waddr] <= child_wdata;
      end
      child_rd_ff <= child_mem[child_raddr];
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      mark_rd_ff <= mark_mem[mark_raddr];
   end

   // read addresses follow the sequencer state
   always_comb begin
      if (state_ff == ST_LK_RD) begin
         child_raddr = {lookup_node_ff, byte_ff};
      end else begin
         child_raddr = {walker_ff[wsel_ff], wbyte_ff[wsel_ff]};
      end
      mark_raddr = lookup_node_ff;
   end

   assign up_byte = upcase(req_chan.byte_req);
   assign report  = (wchars_ff != '0) && !(!missed_ff && mark_rd_ff);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      op_in          = op_ff;
      byte_in        = byte_ff;
      wsel_in        = wsel_ff;
      walker_in      = walker_ff;
      lost_in        = lost_ff;
      wbyte_in       = wbyte_ff;
      in_token_in    = in_token_ff;
      nodes_used_in  = nodes_used_ff;
      pool_full_in   = pool_full_ff;
      lookup_node_in = lookup_node_ff;
      missed_in      = missed_ff;
      line_in        = line_ff;
      col_in         = col_ff;
      wstart_in      = wstart_ff;
      wchars_in      = wchars_ff;
      errs_in        = errs_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_line_in    = out_line_ff;
      out_col_in     = out_col_ff;
      out_len_in     = out_len_ff;
      out_errs_in    = out_errs_ff;
      out_full_in    = out_full_ff;
      child_we       = 1'b0;
      child_waddr    = child_raddr;
      child_wdata    = nodes_used_ff[NW-1:0];
      mark_we        = 1'b0;
      mark_waddr     = walker_ff[wsel_ff];
      mark_wdata     = 1'b1;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         // zero the child table and end marks
         ST_CLEAR: begin
            child_we    = 1'b1;
            child_waddr = sweep_ff;
            child_wdata = '0;
            mark_we     = 1'b1;
            mark_waddr  = sweep_ff[AW-1:ALPHA_W];
            mark_wdata  = 1'b0;
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_LAST) begin
               state_in = ST_IDLE;
            end
         end

         // take an item and dispatch
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               op_in   = req_chan.op;
               byte_in = req_chan.byte_req;
               wsel_in = 2'd0;
               unique case (req_chan.op)
                  OP_DICT_BYTE, OP_DICT_END: begin
                     if (req_chan.op == OP_DICT_END || is_sep(req_chan.byte_req)) begin
                        if (in_token_ff) begin
                           state_in = ST_MARK;
                        end else begin
                           walker_in   = '{default: '0};
                           lost_in     = '0;
                           in_token_in = 1'b0;
                        end
                     end else begin
                        in_token_in = 1'b1;
                        wbyte_in[0] = req_chan.byte_req;
                        wbyte_in[1] = in_token_ff ? req_chan.byte_req : up_byte;
                        wbyte_in[2] = up_byte;
                        state_in    = ST_INS_RD;
                     end
                  end
                  OP_TEXT_BYTE: begin
                     if (is_letter(req_chan.byte_req) || req_chan.byte_req == CHR_APOS) begin
                        if (wchars_ff == '0) begin
                           wstart_in      = col_ff;
                           lookup_node_in = '0;
                           missed_in      = 1'b0;
                        end
                        if (wchars_ff != LEN_MAX) begin
                           wchars_in = wchars_ff + 1'b1;
                        end
                        if (col_ff != COL_MAX) begin
                           col_in = col_ff + 1'b1;
                        end
                        if (wchars_ff == '0 || !missed_ff) begin
                           state_in = ST_LK_RD;
                        end
                     end else begin
                        state_in = ST_FIN_RD;
                     end
                  end
                  default: begin
                     state_in = ST_FIN_RD;
                  end
               endcase
            end
         end

         // child read for the current walker
         ST_INS_RD: begin
            state_in = ST_INS_USE;
         end

         // follow or allocate
         ST_INS_USE: begin
            if (!lost_ff[wsel_ff]) begin
               if (child_rd_ff == '0) begin
                  if (nodes_used_ff < POOL_SIZE) begin
                     child_we           = 1'b1;
                     walker_in[wsel_ff] = nodes_used_ff[NW-1:0];
                     nodes_used_in      = nodes_used_ff + 1'b1;
                  end else begin
                     pool_full_in     = 1'b1;
                     lost_in[wsel_ff] = 1'b1;
                  end
               end else begin
                  walker_in[wsel_ff] = child_rd_ff;
               end
            end
            if (wsel_ff == 2'd2) begin
               state_in = ST_IDLE;
            end else begin
               wsel_in  = wsel_ff + 1'b1;
               state_in = ST_INS_RD;
            end
         end

         // end marks for the finished token, one walker a cycle
         ST_MARK: begin
            mark_we = !lost_ff[wsel_ff];
            if (wsel_ff == 2'd2) begin
               walker_in   = '{default: '0};
               lost_in     = '0;
               in_token_in = 1'b0;
               state_in    = ST_IDLE;
            end else begin
               wsel_in = wsel_ff + 1'b1;
            end
         end

         // text lookup
         ST_LK_RD: begin
            state_in = ST_LK_USE;
         end

         ST_LK_USE: begin
            if (child_rd_ff == '0) begin
               missed_in = 1'b1;
            end else begin
               lookup_node_in = child_rd_ff;
            end
            state_in = ST_IDLE;
         end

         // end mark read for the finished word
         ST_FIN_RD: begin
            state_in = ST_FIN_USE;
         end

         ST_FIN_USE: begin
            if (!(report && out_valid_ff && !rsp_chan.ready)) begin
               if (report) begin
                  errs_in      = (errs_ff != ERR_MAX) ? errs_ff + 1'b1 : errs_ff;
                  out_valid_in = 1'b1;
                  out_line_in  = line_ff;
                  out_col_in   = wstart_ff;
                  out_len_in   = wchars_ff;
                  out_errs_in  = (errs_ff != ERR_MAX) ? errs_ff + 1'b1 : errs_ff;
                  out_full_in  = pool_full_ff;
               end
               wchars_in = '0;
               if (op_ff == OP_TEXT_BYTE) begin
                  if (byte_ff == CHR_LF) begin
                     if (line_ff != LINE_MAX) begin
                        line_in = line_ff + 1'b1;
                     end
                     col_in = COL_W'(1);
                  end else if (is_white(byte_ff) && col_ff != COL_MAX) begin
                     col_in = col_ff + 1'b1;
                  end
               end else begin
                  line_in        = LINE_W'(1);
                  col_in         = COL_W'(1);
                  wstart_in      = COL_W'(1);
                  lookup_node_in = '0;
                  missed_in      = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         sweep_ff       <= '0;
         wsel_ff        <= '0;
         walker_ff      <= '{default: '0};
         lost_ff        <= '0;
         in_token_ff    <= 1'b0;
         nodes_used_ff  <= (NW+1)'(1);
         pool_full_ff   <= 1'b0;
         lookup_node_ff <= '0;
         missed_ff      <= 1'b0;
         line_ff        <= LINE_W'(1);
         col_ff         <= COL_W'(1);
         wstart_ff      <= COL_W'(1);
         wchars_ff      <= '0;
         errs_ff        <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         wsel_ff        <= wsel_in;
         walker_ff      <= walker_in;
         lost_ff        <= lost_in;
         in_token_ff    <= in_token_in;
         nodes_used_ff  <= nodes_used_in;
         pool_full_ff   <= pool_full_in;
         lookup_node_ff <= lookup_node_in;
         missed_ff      <= missed_in;
         line_ff        <= line_in;
         col_ff         <= col_in;
         wstart_ff      <= wstart_in;
         wchars_ff      <= wchars_in;
         errs_ff        <= errs_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      byte_ff     <= byte_in;
      wbyte_ff    <= wbyte_in;
      out_line_ff <= out_line_in;
      out_col_ff  <= out_col_in;
      out_len_ff  <= out_len_in;
      out_errs_ff <= out_errs_in;
      out_full_ff <= out_full_in;
   end

   // result channel
   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.line            = out_line_ff;
   assign rsp_chan.column          = out_col_ff;
   assign rsp_chan.word_length     = out_len_ff;
   assign rsp_chan.error_count     = out_errs_ff;
   assign rsp_chan.dictionary_full = out_full_ff;

endmodule
`default_nettype wire

@@ verif/trie_dictionary_spell_checker_core_checker.sv @@
// checker: watches both channels, predicts misspelling reports, compares them
`timescale 1ns / 100ps
`default_nettype none
module trie_dictionary_spell_checker_core_checker #(
   parameter int unsigned NODE_COUNT = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   tdsc_req_if       req_chan,
   tdsc_rsp_if       rsp_chan,
   output int        fail_count,
   output int        reports_pending
);
   import tdsc_pkg::*;

   typedef struct packed {
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  column;
      logic [LEN_W-1:0]  word_length;
      logic [ERR_W-1:0]  error_count;
      logic              dictionary_full;
   } report_type;

   // shadow trie and scanner state
   logic [9:0]        trie_child [NODE_COUNT*256];
   logic              word_end [NODE_COUNT];
   int unsigned       nodes_taken;
   logic [9:0]        walker [3];
   logic              walker_lost [3];
   logic              token_open;
   logic [9:0]        probe_node;
   logic              probe_missed;
   logic [LINE_W-1:0] cur_line;
   logic [COL_W-1:0]  cur_col;
   logic [COL_W-1:0]  start_col;
   logic [LEN_W-1:0]  char_count;
   logic [ERR_W-1:0]  misspellings;
   logic              pool_exhausted;
   logic              cleared = 1'b0;
   report_type        expected_reports [$];

   function automatic logic lower_ch(input logic [7:0] b);
      return b >= 8'h61 && b <= 8'h7a;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] b);
      return lower_ch(b) ? b - 8'h20 : b;
   endfunction

   function automatic logic word_ch(input logic [7:0] b);
      return lower_ch(b) || (b >= 8'h41 && b <= 8'h5a) || b == CHR_APOS;
   endfunction

   function automatic logic blank_ch(input logic [7:0] b);
      return b == CHR_SPACE || (b >= 8'h09 && b <= 8'h0d);
   endfunction

   function automatic logic split_ch(input logic [7:0] b);
      return b == CHR_SPACE || b == CHR_DOT || b == CHR_COMMA || b == CHR_QUEST ||
             b == CHR_TAB || b == CHR_LF;
   endfunction

   // one insertion walker steps on one byte, taking a node if needed
   task automatic walk_insert(input int w, input logic [7:0] b);
      int unsigned idx;
      logic [9:0] nxt;
      if (!walker_lost[w]) begin
         idx = walker[w] * 256 + b;
         nxt = trie_child[idx];
         if (nxt == 0) begin
            if (nodes_taken < NODE_COUNT) begin
               nxt = nodes_taken[9:0];
               nodes_taken++;
               trie_child[idx] = nxt;
               walker[w] = nxt;
            end else begin
               pool_exhausted = 1'b1;
               walker_lost[w] = 1'b1;
            end
         end else begin
            walker[w] = nxt;
         end
      end
   endtask

   task automatic close_token();
      for (int w = 0; w < 3; w++) begin
         if (token_open && !walker_lost[w]) word_end[walker[w]] = 1'b1;
         walker[w] = '0;
         walker_lost[w] = 1'b0;
      end
      token_open = 1'b0;
   endtask

   task automatic close_word();
      report_type r;
      if (char_count != 0) begin
         if (probe_missed || !word_end[probe_node]) begin
            if (misspellings != ERR_MAX) misspellings++;
            r.line = cur_line;
            r.column = start_col;
            r.word_length = char_count;
            r.error_count = misspellings;
            r.dictionary_full = pool_exhausted;
            expected_reports.push_back(r);
         end
         char_count = '0;
      end
   endtask

   // predict reports for one accepted item
   task automatic predict_item(input logic [OP_W-1:0] op, input logic [7:0] b);
      logic first;
      logic [9:0] nxt;
      case (op)
         OP_DICT_BYTE: begin
            if (split_ch(b)) begin
               close_token();
            end else begin
               first = !token_open;
               token_open = 1'b1;
               walk_insert(0, b);
               walk_insert(1, first ? to_upper(b) : b);
               walk_insert(2, to_upper(b));
            end
         end
         OP_DICT_END: close_token();
         OP_TEXT_BYTE: begin
            if (word_ch(b)) begin
               if (char_count == 0) begin
                  start_col = cur_col;
                  probe_node = '0;
                  probe_missed = 1'b0;
               end
               if (!probe_missed) begin
                  nxt = trie_child[probe_node * 256 + b];
                  if (nxt == 0) probe_missed = 1'b1;
                  else probe_node = nxt;
               end
               if (char_count != LEN_MAX) char_count++;
               if (cur_col != COL_MAX) cur_col++;
            end else begin
               if (blank_ch(b) && cur_col != COL_MAX) cur_col++;
               close_word();
               if (b == CHR_LF) begin
                  if (cur_line != LINE_MAX) cur_line++;
                  cur_col = 1;
               end
            end
         end
         default: begin
            close_word();
            cur_line = 1;
            cur_col = 1;
            start_col = 1;
            char_count = '0;
            probe_node = '0;
            probe_missed = 1'b0;
         end
      endcase
   endtask

   // reset the shadow once, then track both channels
   always @(posedge clock) begin
      report_type got, want;
      if (reset) begin
         if (!cleared) begin
            foreach (trie_child[i]) trie_child[i] = '0;
            foreach (word_end[i]) word_end[i] = 1'b0;
            cleared = 1'b1;
         end
         fail_count = 0;
         nodes_taken = 1;
         token_open = 1'b0;
         for (int w = 0; w < 3; w++) begin
            walker[w] = '0;
            walker_lost[w] = 1'b0;
         end
         probe_node = '0;
         probe_missed = 1'b0;
         cur_line = 1;
         cur_col = 1;
         start_col = 1;
         char_count = '0;
         misspellings = '0;
         pool_exhausted = 1'b0;
         expected_reports.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.line, rsp_chan.column, rsp_chan.word_length,
                    rsp_chan.error_count, rsp_chan.dictionary_full};
            if (expected_reports.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected report, expected none, actual %p", $time, got);
            end else begin
               want = expected_reports.pop_front();
               if (got.line !== want.line || got.column !== want.column ||
                   got.word_length !== want.word_length ||
                   got.error_count !== want.error_count ||
                   got.dictionary_full !== want.dictionary_full) begin
                  fail_count++;
                  $display("%0t: report mismatch, expected %p, actual %p", $time, want, got);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) predict_item(req_chan.op, req_chan.byte_req);
      end
      reports_pending = expected_reports.size();
   end
endmodule
`default_nettype wire

@@ verif/trie_dictionary_spell_checker_core_test.sv @@
// testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict
`timescale 1ns / 100ps
`default_nettype none
module trie_dictionary_spell_checker_core_test;
   import tdsc_pkg::*;

   localparam int STALL_LIMIT = 1000000;

   logic clock;
   logic reset;
   int   fail_count;
   int   reports_pending;
   int   send_idle;
   int   recv_idle;
   bit   hold_receiver;
   int   quiet_cycles;
   string vocab [16] = '{"the", "cat", "dog", "run", "it's", "apple", "tree", "a", "an",
                         "blue", "sky", "house", "over", "under", "quick", "zebra"};

   tdsc_req_if req_chan ();
   tdsc_rsp_if rsp_chan ();

   trie_dictionary_spell_checker_core uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   trie_dictionary_spell_checker_core_checker #(.NODE_COUNT(1024)) scoreboard (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .fail_count(fail_count), .reports_pending(reports_pending)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hand one item to the block, with an occasional gap before it
   task automatic send(input logic [OP_W-1:0] op, input logic [7:0] b);
      if (int'($urandom_range(99)) < send_idle) begin
         req_chan.valid <= 1'b0;
         repeat (1 + $urandom_range(3)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.byte_req <= b;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_str(input logic [OP_W-1:0] op, input string s);
      for (int i = 0; i < s.len(); i++) send(op, s[i]);
   endtask

   // stop offering and wait until every report has come
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
   endtask

   // dictionary tokens from the vocabulary, with split bytes in between
   task automatic load_vocab(input int tokens);
      logic [7:0] seps [6] = '{CHR_SPACE, CHR_DOT, CHR_COMMA, CHR_QUEST, CHR_TAB, CHR_LF};
      for (int t = 0; t < tokens; t++) begin
         send_str(OP_DICT_BYTE, vocab[$urandom_range(15)]);
         send(OP_DICT_BYTE, seps[$urandom_range(5)]);
      end
   endtask

   // long tokens, mostly lowercase so the three variants part early and use up the pool
   task automatic load_noise(input int tokens);
      logic [7:0] b;
      for (int t = 0; t < tokens; t++) begin
         repeat (10 + $urandom_range(10)) begin
            if ($urandom_range(3) != 0) begin
               b = 8'(8'h61 + $urandom_range(25));
            end else begin
               do b = 8'($urandom_range(255)); while (b == CHR_SPACE || b == CHR_DOT ||
                  b == CHR_COMMA || b == CHR_QUEST || b == CHR_TAB || b == CHR_LF);
            end
            send(OP_DICT_BYTE, b);
         end
         if ($urandom_range(3) == 0) send(OP_DICT_END, 8'($urandom_range(255)));
         else send(OP_DICT_BYTE, CHR_SPACE);
      end
   endtask

   function automatic logic [7:0] to_cap(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7a) ? b - 8'h20 : b;
   endfunction

   // text: known words, case variants, typos, random words and noise
   task automatic scan_text(input int count);
      string w;
      int sent;
      int k;
      logic [7:0] ch;
      logic [7:0] gaps [9] = '{CHR_SPACE, CHR_SPACE, CHR_LF, CHR_TAB, CHR_DOT, CHR_COMMA,
                               8'h2d, 8'h21, CHR_CR};
      sent = 0;
      while (sent < count) begin
         k = $urandom_range(99);
         if (k < 60) begin
            w = vocab[$urandom_range(15)];
            case ($urandom_range(4))
               0: w[0] = to_cap(w[0]);
               1: w = w.toupper();
               2: w[$urandom_range(w.len() - 1)] = 8'(8'h61 + $urandom_range(25));
               default: ;
            endcase
         end else if (k < 85) begin
            w = "";
            repeat (1 + $urandom_range(7)) begin
               ch = 8'(8'h41 + $urandom_range(1) * 8'h20 + $urandom_range(25));
               w = {w, string'(ch)};
            end
         end else begin
            w = "";
         end
         send_str(OP_TEXT_BYTE, w);
         sent += w.len() + 1;
         if (k >= 85 && k < 95) send(OP_TEXT_BYTE, 8'($urandom_range(255)));
         else if (k >= 95) send(OP_TEXT_END, 8'($urandom_range(255)));
         else send(OP_TEXT_BYTE, gaps[$urandom_range(8)]);
      end
   endtask

   // receiver: random stalls, or one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_receiver) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_receiver = 1'b0;
         end else begin
            rsp_chan.ready <= int'($urandom_range(99)) >= recv_idle;
         end
      end
   end

   // watchdog on cycles with no accepted item and no taken report
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("trie_dictionary_spell_checker_core_test: done, errors");
         $finish;
      end
   end

   // stimulus and verdict
   initial begin
      string long_word;
      hold_receiver = 1'b0;
      send_idle = 11;
      recv_idle = 51;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.op <= OP_DICT_BYTE;
      req_chan.byte_req <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: apostrophe and non-ascii in a token, dictionary end closing a token
      send_str(OP_DICT_BYTE, "ab'");
      send(OP_DICT_BYTE, 8'hff);
      send(OP_DICT_BYTE, CHR_COMMA);
      send_str(OP_DICT_BYTE, "ok");
      send(OP_DICT_END, 8'h00);
      // first-upper variant found, all-upper found, prefix unmarked, file end checks word
      send_str(OP_TEXT_BYTE, "Ok OK a");
      send(OP_TEXT_BYTE, 8'hff);
      send(OP_TEXT_BYTE, CHR_LF);
      send(OP_TEXT_BYTE, 8'h00);
      send_str(OP_TEXT_BYTE, "x'z");
      send(OP_TEXT_END, 8'hff);

      // phase one: real vocabulary and text
      load_vocab(16);
      send(OP_DICT_END, 8'h00);
      scan_text(70);
      drain();

      // phase two: fill the node pool, then one very long word
      send_idle = 51;
      recv_idle = 11;
      load_noise(26);
      long_word = "";
      repeat (258) long_word = {long_word, "q"};
      send_str(OP_TEXT_BYTE, long_word);
      send(OP_TEXT_BYTE, CHR_SPACE);
      scan_text(40);

      // phase three: no idling, long receiver hold-off while text keeps coming
      send_idle = 0;
      recv_idle = 0;
      hold_receiver = 1'b1;
      scan_text(70);
      send(OP_TEXT_END, 8'h00);
      drain();

      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("trie_dictionary_spell_checker_core_test: done, clean");
      else
         $display("trie_dictionary_spell_checker_core_test: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/tdsc_pkg.sv
rtl/tdsc_req_if.sv
rtl/tdsc_rsp_if.sv
rtl/trie_dictionary_spell_checker_core.sv
verif/trie_dictionary_spell_checker_core_checker.sv
verif/trie_dictionary_spell_checker_core_test.sv
